>>> rtl/htps_pkg.sv
// Shared types and constants for the hash table probe/store/replace unit.
// No dependencies; every other file refers to this package by scoped names.
package htps_pkg;

  localparam int TABLE_ENTRIES = 65536;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 16;
  localparam int MOVE_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int THR_W   = 15;
  localparam int CNT_W   = 32;

  // Configuration register indexes
  localparam logic CFG_CURRENT_AGE    = 1'b0;
  localparam logic CFG_MATE_THRESHOLD = 1'b1;
  localparam logic [THR_W-1:0] MATE_THRESHOLD_RST = 15'd31000;

  // Raw request codes on in_req_type
  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // store_result codes
  localparam logic [1:0] STORE_DROPPED = 2'd0;
  localparam logic [1:0] STORE_WRITE   = 2'd1;
  localparam logic [1:0] STORE_REPLACE = 2'd2;

  typedef enum logic [1:0] {
    OP_PROBE,
    OP_STORE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } st_t;

  // Slot layout: key [63:0], score [79:64], move [95:80], bound [103:96],
  // depth [111:104], age [119:112]
  typedef struct packed {
    logic [BYTE_W-1:0]  age;
    logic [BYTE_W-1:0]  depth;
    logic [BYTE_W-1:0]  bound;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // Classified request as queued between front and back
  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;   // already ply adjusted and saturated
    logic [BYTE_W-1:0]  depth;
    logic [BYTE_W-1:0]  bound;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [SCORE_W-1:0] entry_score;
    logic [MOVE_W-1:0]  entry_move;
    logic [BYTE_W-1:0]  entry_bound;
    logic [BYTE_W-1:0]  entry_depth;
    logic [BYTE_W-1:0]  entry_age;
    logic [1:0]         store_result;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   write_count;
    logic [CNT_W-1:0]   rewrite_count;
  } result_t;

endpackage

>>> rtl/hash_table_probe_store_replace_unit.sv
// Top level of the hash table probe/store/replace unit: configuration
// registers, front queue and back engine. Depends on htps_pkg, htps_front, htps_back.
//
// Direct-mapped table of 65536 slots, each holding a 64-bit key, score, move,
// bound, depth and age; a request's slot is the low 16 bits of its key.
// A probe returns the slot when its key matches and counts hits and misses.
// A store writes an empty slot (key zero) or replaces when the key matches,
// the slot's age differs from current_age, or the new depth is at least the
// old depth minus two; else it is dropped. Scores at or beyond the mate
// threshold have ply added (subtracted when negative), saturated to 16 bits.
// Every transfer in yields exactly one result transfer carrying the counters
// after the request. Probe and store read the slot from the single table
// memory when taken from the queue, then decide, write back and load the
// result register in the execute state; a queue of two requests in front
// keeps input transfers flowing while a result waits. A clear request sweeps
// the table one slot per cycle and then returns its result. After reset the
// same sweep runs with in_stall held high; configuration writes are taken
// at any time (cfg_ready is always high) but must only change while no
// request is in flight.
module hash_table_probe_store_replace_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [htps_pkg::KEY_W-1:0]         in_key,
  input  logic [htps_pkg::MOVE_W-1:0]        in_best_move,
  input  logic signed [htps_pkg::SCORE_W-1:0] in_score,
  input  logic [htps_pkg::BYTE_W-1:0]        in_search_depth,
  input  logic [htps_pkg::BYTE_W-1:0]        in_bound_kind,
  input  logic [htps_pkg::BYTE_W-1:0]        in_ply,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic signed [htps_pkg::SCORE_W-1:0] out_entry_score,
  output logic [htps_pkg::MOVE_W-1:0]        out_entry_move,
  output logic [htps_pkg::BYTE_W-1:0]        out_entry_bound,
  output logic [htps_pkg::BYTE_W-1:0]        out_entry_depth,
  output logic [htps_pkg::BYTE_W-1:0]        out_entry_age,
  output logic [1:0]                         out_store_result,
  output logic [htps_pkg::CNT_W-1:0]         out_hit_count,
  output logic [htps_pkg::CNT_W-1:0]         out_miss_count,
  output logic [htps_pkg::CNT_W-1:0]         out_write_count,
  output logic [htps_pkg::CNT_W-1:0]         out_rewrite_count,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [htps_pkg::THR_W-1:0]         cfg_wdata
);

  logic [htps_pkg::BYTE_W-1:0] current_age_r;
  logic [htps_pkg::THR_W-1:0]  mate_threshold_r;
  logic                        cfg_we;
  logic                        q_valid, q_pop, init_busy;
  htps_pkg::item_t             q_item;
  htps_pkg::result_t           res;

  // config registers, always ready
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_age_r    <= '0;
      mate_threshold_r <= htps_pkg::MATE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        htps_pkg::CFG_CURRENT_AGE:    current_age_r    <= cfg_wdata[htps_pkg::BYTE_W-1:0];
        htps_pkg::CFG_MATE_THRESHOLD: mate_threshold_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  htps_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_best_move    (in_best_move),
    .in_score        (in_score),
    .in_search_depth (in_search_depth),
    .in_bound_kind   (in_bound_kind),
    .in_ply          (in_ply),
    .mate_threshold  (mate_threshold_r),
    .block           (init_busy),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  htps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .current_age (current_age_r),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_found         = res.found;
  assign out_entry_score   = res.entry_score;
  assign out_entry_move    = res.entry_move;
  assign out_entry_bound   = res.entry_bound;
  assign out_entry_depth   = res.entry_depth;
  assign out_entry_age     = res.entry_age;
  assign out_store_result  = res.store_result;
  assign out_hit_count     = res.hit_count;
  assign out_miss_count    = res.miss_count;
  assign out_write_count   = res.write_count;
  assign out_rewrite_count = res.rewrite_count;

endmodule

>>> rtl/htps_front.sv
// Front end: takes requests, classifies them, applies mate ply adjustment
// and holds them in a two-entry queue. Depends on htps_pkg.
module htps_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [htps_pkg::KEY_W-1:0]   in_key,
  input  logic [htps_pkg::MOVE_W-1:0]  in_best_move,
  input  logic signed [htps_pkg::SCORE_W-1:0] in_score,
  input  logic [htps_pkg::BYTE_W-1:0]  in_search_depth,
  input  logic [htps_pkg::BYTE_W-1:0]  in_bound_kind,
  input  logic [htps_pkg::BYTE_W-1:0]  in_ply,
  input  logic [htps_pkg::THR_W-1:0]   mate_threshold,
  input  logic                         block,
  output logic                         q_valid,
  output htps_pkg::item_t              q_item,
  input  logic                         q_pop
);

  htps_pkg::item_t  q_mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push;
  htps_pkg::item_t  item_in;
  logic signed [17:0] s18, t18, p18, adj18;

  // Mate distance adjustment, saturating to 16 bits
  always_comb begin
    s18 = {{2{in_score[15]}}, in_score};
    t18 = {3'b000, mate_threshold};
    p18 = {10'b0, in_ply};
    if (s18 >= t18) begin
      adj18 = s18 + p18;
    end else if (s18 <= -t18) begin
      adj18 = s18 - p18;
    end else begin
      adj18 = s18;
    end
  end

  always_comb begin
    case (in_req_type)
      htps_pkg::REQ_PROBE: item_in.op = htps_pkg::OP_PROBE;
      htps_pkg::REQ_STORE: item_in.op = htps_pkg::OP_STORE;
      htps_pkg::REQ_CLEAR: item_in.op = htps_pkg::OP_CLEAR;
      default:             item_in.op = htps_pkg::OP_NOP;
    endcase
    item_in.key   = in_key;
    item_in.move  = in_best_move;
    item_in.depth = in_search_depth;
    item_in.bound = in_bound_kind;
    if (adj18 > 18'sd32767) begin
      item_in.score = 16'h7FFF;
    end else if (adj18 < -18'sd32768) begin
      item_in.score = 16'h8000;
    end else begin
      item_in.score = adj18[15:0];
    end
  end

  assign in_stall = (count_r == 2'd2) || block;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

>>> rtl/htps_back.sv
// Back end: slot table, read-modify-write engine, clearing sweep, counters
// and the result register. Depends on htps_pkg.
module htps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  htps_pkg::item_t             q_item,
  output logic                        q_pop,
  input  logic [htps_pkg::BYTE_W-1:0] current_age,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output htps_pkg::result_t           out_res
);

  htps_pkg::entry_t  mem [htps_pkg::TABLE_ENTRIES];
  htps_pkg::entry_t  rdata_r;
  htps_pkg::item_t   item_r;
  htps_pkg::st_t     state_r, state_nxt;
  logic [htps_pkg::SLOT_W-1:0] clr_ptr_r, clr_ptr_nxt;
  logic              clr_req_r, clr_req_nxt;
  logic [htps_pkg::CNT_W-1:0] hits_r, hits_nxt, misses_r, misses_nxt;
  logic [htps_pkg::CNT_W-1:0] writes_r, writes_nxt, rewrites_r, rewrites_nxt;
  logic              out_valid_r, out_free, out_load;
  htps_pkg::result_t res_r, res;
  logic              we;
  logic [htps_pkg::SLOT_W-1:0] waddr;
  htps_pkg::entry_t  wdata, new_entry;
  logic              key_hit;
  logic signed [9:0] new_d, old_d2;

  localparam logic [htps_pkg::SLOT_W-1:0] LAST_SLOT =
    htps_pkg::SLOT_W'(htps_pkg::TABLE_ENTRIES - 1);

  assign out_free  = !out_valid_r || !out_stall;
  assign init_busy = (state_r == htps_pkg::ST_CLEAR) && !clr_req_r;
  assign key_hit   = (rdata_r.key == item_r.key);
  assign new_d     = {2'b00, item_r.depth};
  assign old_d2    = {2'b00, rdata_r.depth} - 10'sd2;

  always_comb begin
    new_entry.key   = item_r.key;
    new_entry.score = item_r.score;
    new_entry.move  = item_r.move;
    new_entry.bound = item_r.bound;
    new_entry.depth = item_r.depth;
    new_entry.age   = current_age;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_ptr_nxt  = clr_ptr_r;
    clr_req_nxt  = clr_req_r;
    hits_nxt     = hits_r;
    misses_nxt   = misses_r;
    writes_nxt   = writes_r;
    rewrites_nxt = rewrites_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    we           = 1'b0;
    waddr        = item_r.key[htps_pkg::SLOT_W-1:0];
    wdata        = new_entry;
    res          = '0;
    case (state_r)
      htps_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == htps_pkg::OP_CLEAR) begin
            state_nxt    = htps_pkg::ST_CLEAR;
            clr_req_nxt  = 1'b1;
            hits_nxt     = '0;
            misses_nxt   = '0;
            writes_nxt   = '0;
            rewrites_nxt = '0;
          end else begin
            state_nxt = htps_pkg::ST_EXEC;
          end
        end
      end
      htps_pkg::ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = htps_pkg::ST_IDLE;
          case (item_r.op)
            htps_pkg::OP_PROBE: begin
              if (key_hit) begin
                hits_nxt        = hits_r + 1'b1;
                res.found       = 1'b1;
                res.entry_score = rdata_r.score;
                res.entry_move  = rdata_r.move;
                res.entry_bound = rdata_r.bound;
                res.entry_depth = rdata_r.depth;
                res.entry_age   = rdata_r.age;
              end else begin
                misses_nxt = misses_r + 1'b1;
              end
            end
            htps_pkg::OP_STORE: begin
              if (rdata_r.key == '0) begin
                we               = 1'b1;
                writes_nxt       = writes_r + 1'b1;
                res.store_result = htps_pkg::STORE_WRITE;
              end else if (key_hit || (rdata_r.age != current_age) ||
                           (new_d >= old_d2)) begin
                we               = 1'b1;
                rewrites_nxt     = rewrites_r + 1'b1;
                res.store_result = htps_pkg::STORE_REPLACE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      htps_pkg::ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_ptr_r;
        wdata       = '0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_SLOT) begin
          state_nxt   = clr_req_r ? htps_pkg::ST_EXEC : htps_pkg::ST_IDLE;
          clr_req_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = htps_pkg::ST_IDLE;
      end
    endcase
    res.hit_count     = hits_nxt;
    res.miss_count    = misses_nxt;
    res.write_count   = writes_nxt;
    res.rewrite_count = rewrites_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htps_pkg::ST_CLEAR;
      clr_ptr_r   <= '0;
      clr_req_r   <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      writes_r    <= '0;
      rewrites_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      clr_req_r   <= clr_req_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      writes_r    <= writes_nxt;
      rewrites_r  <= rewrites_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (out_load) begin
      res_r <= res;
    end
  end

  // slot table: registered read at dispatch, write in execute or sweep
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata_r <= mem[q_item.key[htps_pkg::SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == htps_pkg::ST_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing sweep");

  a_exec_write_is_store: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == htps_pkg::ST_EXEC) && we) |->
      (item_r.op == htps_pkg::OP_STORE) && out_load)
    else $error("table write without a completing store");

  a_clear_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (item_r.op == htps_pkg::OP_CLEAR)) |->
      (hits_nxt == '0) && (misses_nxt == '0) &&
      (writes_nxt == '0) && (rewrites_nxt == '0))
    else $error("clear result with nonzero counters");

  a_ptr_home_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == htps_pkg::ST_IDLE) |-> (clr_ptr_r == '0))
    else $error("sweep pointer not home outside sweep");

endmodule
